>>> hdl/sort_pkg.sv
// Shared types and constants of the score-ordered request table.
// Used by sort_ctrl, sort_dp and score_ordered_request_table; depends on nothing.
package sort_pkg;

	localparam int DEPTH    = 64;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = IDX_W + 1;
	localparam int KEY_W    = 20;
	localparam int SIZE_W   = 16;
	localparam int WEIGHT_W = 24;
	localparam int POS_W    = 6;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;
	localparam int PROD_W   = SIZE_W + WEIGHT_W;

	localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REM_KEY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REM_POS = 2'd2;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MERGED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [SIZE_W-1:0]   size;
		logic [WEIGHT_W-1:0] weight;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_start;
		logic decide;
		logic copy_start;
		logic place;
		logic respond;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic                busy;
		logic [STATUS_W-1:0] outcome;
		logic [CNT_W-1:0]    count;
	} sts_t;

endpackage

>>> hdl/sort_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used by sort_dp for the two table banks.
module sort_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/sort_ctrl.sv
// Sequencing state machine of the score-ordered request table.
// Depends on sort_pkg for the command and status structs.
module sort_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  sort_pkg::sts_t  sts,
	output sort_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_COPY,
		S_PLACE,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   rewrite;

	assign rewrite = (sts.outcome == sort_pkg::ST_INSERTED) ||
		(sts.outcome == sort_pkg::ST_MERGED) || (sts.outcome == sort_pkg::ST_REMOVED);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.scan_start = (state_q == S_IDLE) && in_valid;
		cmd.decide     = (state_q == S_DECIDE);
		cmd.copy_start = (state_q == S_DECIDE) && rewrite;
		cmd.place      = (state_q == S_PLACE);
		cmd.respond    = (state_q == S_RESP) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.respond) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!sts.busy) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= rewrite ? S_COPY : S_RESP;
				end
				S_COPY: begin
					if (!sts.busy) state_q <= S_PLACE;
				end
				S_PLACE: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (cmd.respond) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/sort_dp.sv
// Datapath of the score-ordered request table: two table banks, the scan and
// copy pipeline, the score compare and the result registers. Depends on sort_pkg and sort_ram.
module sort_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sort_pkg::cmd_t                    cmd,
	output sort_pkg::sts_t                    sts,
	input  logic [sort_pkg::KIND_W-1:0]       kind,
	input  logic [sort_pkg::KEY_W-1:0]        item_key,
	input  logic [sort_pkg::SIZE_W-1:0]       item_size,
	input  logic [sort_pkg::WEIGHT_W-1:0]     item_weight,
	input  logic [sort_pkg::POS_W-1:0]        position,
	output logic [sort_pkg::STATUS_W-1:0]     status,
	output logic [sort_pkg::KEY_W-1:0]        out_key,
	output logic [sort_pkg::SIZE_W-1:0]       out_size,
	output logic [sort_pkg::WEIGHT_W-1:0]     out_weight,
	output logic [sort_pkg::CNT_W-1:0]        entries_held
);

	localparam int IDX_W = sort_pkg::IDX_W;
	localparam int CNT_W = sort_pkg::CNT_W;

	// Captured request.
	logic [sort_pkg::KIND_W-1:0]   kind_q;
	logic [sort_pkg::KEY_W-1:0]    key_q;
	logic [sort_pkg::SIZE_W-1:0]   size_q;
	logic [sort_pkg::WEIGHT_W-1:0] weight_q;
	logic [sort_pkg::POS_W-1:0]    pos_q;

	logic [CNT_W-1:0] count_q;
	logic             bank_q;

	// Read stream.
	logic             scan_q;
	logic             copy_mode_q;
	logic [CNT_W-1:0] issue_q;
	logic             rd_v_s1;
	logic [CNT_W-1:0] rd_idx_s1;
	logic             more;

	// Scan results.
	logic             found_q;
	logic [CNT_W-1:0] match_q;
	sort_pkg::entry_t hit_q;

	// Decision.
	logic [sort_pkg::STATUS_W-1:0] outcome;
	logic [sort_pkg::STATUS_W-1:0] outcome_q;
	logic [sort_pkg::WEIGHT_W-1:0] new_w_q;
	logic                          ins_mode_q;
	logic [sort_pkg::WEIGHT_W:0]   wsum;

	// Copy stage.
	logic                          v_s2;
	sort_pkg::entry_t              e_s2;
	logic [sort_pkg::PROD_W-1:0]   pa_s2;
	logic [sort_pkg::PROD_W-1:0]   pb_s2;
	logic [CNT_W-1:0]              kept_q;
	logic                          placed_q;
	logic [CNT_W-1:0]              ins_q;
	logic                          place_now;

	// Memory ports.
	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	sort_pkg::entry_t              wr_data;
	logic [sort_pkg::ENTRY_W-1:0]  rd0;
	logic [sort_pkg::ENTRY_W-1:0]  rd1;
	sort_pkg::entry_t              rd_e;
	logic                          match_now;
	logic                          skip_now;

	sort_ram #(.WIDTH(sort_pkg::ENTRY_W), .DEPTH(sort_pkg::DEPTH)) u_bank0 (
		.clk   (clk),
		.we    (wr_en && bank_q),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (rd0)
	);

	sort_ram #(.WIDTH(sort_pkg::ENTRY_W), .DEPTH(sort_pkg::DEPTH)) u_bank1 (
		.clk   (clk),
		.we    (wr_en && !bank_q),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (rd1)
	);

	assign rd_e = bank_q ? rd1 : rd0;
	assign more = scan_q && (issue_q < count_q);

	assign match_now = rd_v_s1 && !copy_mode_q && (
		(((kind_q == sort_pkg::KIND_ADD) || (kind_q == sort_pkg::KIND_REM_KEY)) &&
			(rd_e.key == key_q)) ||
		((kind_q == sort_pkg::KIND_REM_POS) && (rd_idx_s1 == CNT_W'(pos_q))));
	assign skip_now = found_q && (rd_idx_s1 == match_q);

	// The first kept entry whose score is not above the new one takes its place.
	assign place_now = v_s2 && ins_mode_q && !placed_q && !(pa_s2 > pb_s2);

	always_comb begin
		if (v_s2) begin
			wr_en   = 1'b1;
			wr_addr = IDX_W'(kept_q + CNT_W'(placed_q || place_now));
			wr_data = e_s2;
		end else begin
			wr_en          = cmd.place && ins_mode_q;
			wr_addr        = placed_q ? ins_q[IDX_W-1:0] : kept_q[IDX_W-1:0];
			wr_data.key    = key_q;
			wr_data.size   = size_q;
			wr_data.weight = new_w_q;
		end
	end

	always_comb begin
		priority if (kind_q == sort_pkg::KIND_ADD) begin
			if (found_q) outcome = sort_pkg::ST_MERGED;
			else if (count_q == CNT_W'(sort_pkg::DEPTH)) outcome = sort_pkg::ST_FULL;
			else outcome = sort_pkg::ST_INSERTED;
		end else if ((kind_q == sort_pkg::KIND_REM_KEY) || (kind_q == sort_pkg::KIND_REM_POS)) begin
			outcome = found_q ? sort_pkg::ST_REMOVED : sort_pkg::ST_NOT_FOUND;
		end else begin
			outcome = sort_pkg::ST_NOT_FOUND;
		end
	end

	assign wsum = {1'b0, weight_q} + {1'b0, hit_q.weight};

	assign sts.busy    = scan_q || rd_v_s1 || v_s2;
	assign sts.outcome = outcome;
	assign sts.count   = count_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			bank_q      <= 1'b0;
			scan_q      <= 1'b0;
			copy_mode_q <= 1'b0;
			issue_q     <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			v_s2        <= 1'b0;
			kept_q      <= '0;
			placed_q    <= 1'b0;
			ins_q       <= '0;
			ins_mode_q  <= 1'b0;
			outcome_q   <= sort_pkg::ST_NOT_FOUND;
		end else begin
			rd_v_s1 <= more;
			v_s2    <= rd_v_s1 && copy_mode_q && !skip_now;

			if (cmd.scan_start) begin
				scan_q      <= 1'b1;
				copy_mode_q <= 1'b0;
				issue_q     <= '0;
				found_q     <= 1'b0;
			end else if (cmd.copy_start) begin
				scan_q      <= 1'b1;
				copy_mode_q <= 1'b1;
				issue_q     <= '0;
				kept_q      <= '0;
				placed_q    <= 1'b0;
				ins_q       <= '0;
			end else begin
				if (more) issue_q <= issue_q + 1'b1;
				else scan_q <= 1'b0;
				if (match_now && !found_q) found_q <= 1'b1;
				if (v_s2) kept_q <= kept_q + 1'b1;
				if (place_now) begin
					placed_q <= 1'b1;
					ins_q    <= kept_q;
				end
			end

			if (cmd.decide) begin
				outcome_q  <= outcome;
				ins_mode_q <= (outcome == sort_pkg::ST_INSERTED) ||
					(outcome == sort_pkg::ST_MERGED);
			end

			if (cmd.place) begin
				bank_q <= !bank_q;
				if (outcome_q == sort_pkg::ST_INSERTED) count_q <= count_q + 1'b1;
				else if (outcome_q == sort_pkg::ST_REMOVED) count_q <= count_q - 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			key_q    <= item_key;
			size_q   <= item_size;
			weight_q <= item_weight;
			pos_q    <= position;
		end
		rd_idx_s1 <= issue_q;
		if (match_now && !found_q) begin
			match_q <= rd_idx_s1;
			hit_q   <= rd_e;
		end
		if (cmd.decide) begin
			if (found_q && (kind_q == sort_pkg::KIND_ADD)) begin
				new_w_q <= wsum[sort_pkg::WEIGHT_W] ? '1 : wsum[sort_pkg::WEIGHT_W-1:0];
			end else begin
				new_w_q <= weight_q;
			end
		end
		e_s2  <= rd_e;
		pa_s2 <= sort_pkg::PROD_W'(rd_e.weight * size_q);
		pb_s2 <= sort_pkg::PROD_W'(new_w_q * rd_e.size);
		if (cmd.respond) begin
			status       <= outcome_q;
			entries_held <= count_q;
			unique case (outcome_q)
				sort_pkg::ST_INSERTED, sort_pkg::ST_MERGED: begin
					out_key    <= key_q;
					out_size   <= '0;
					out_weight <= new_w_q;
				end
				sort_pkg::ST_REMOVED: begin
					out_key    <= hit_q.key;
					out_size   <= hit_q.size;
					out_weight <= hit_q.weight;
				end
				default: begin
					out_key    <= '0;
					out_size   <= '0;
					out_weight <= '0;
				end
			endcase
		end
	end

endmodule

>>> hdl/score_ordered_request_table.sv
// For an insert, merge or removal, a read pass over the current bank finds the key or position,
// then a copy pass into the other bank skips any matched entry and, for an insert or merge,
// finds the new slot by cross-multiplied score; a drop or a miss takes the read pass only.
// A new word is accepted only in the idle state, once the previous result has been registered.
// Reset clears the entry count and control state at once; no clearing pass, table contents
// are undefined until written and never read beyond the count.
module score_ordered_request_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sort_pkg::KIND_W-1:0]       kind,
	input  logic [sort_pkg::KEY_W-1:0]        item_key,
	input  logic [sort_pkg::SIZE_W-1:0]       item_size,
	input  logic [sort_pkg::WEIGHT_W-1:0]     item_weight,
	input  logic [sort_pkg::POS_W-1:0]        position,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sort_pkg::STATUS_W-1:0]     status,
	output logic [sort_pkg::KEY_W-1:0]        out_key,
	output logic [sort_pkg::SIZE_W-1:0]       out_size,
	output logic [sort_pkg::WEIGHT_W-1:0]     out_weight,
	output logic [sort_pkg::CNT_W-1:0]        entries_held
);

	// The controller sequences scan, decision, copy, placement and response; the
	// datapath owns the two banks, which swap roles after every rewrite.
	sort_pkg::cmd_t cmd;
	sort_pkg::sts_t sts;

	sort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The result register is only reloaded when it is empty or being taken, so a new
	// word may be accepted while the previous result still waits.
	sort_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.item_key     (item_key),
		.item_size    (item_size),
		.item_weight  (item_weight),
		.position     (position),
		.status       (status),
		.out_key      (out_key),
		.out_size     (out_size),
		.out_weight   (out_weight),
		.entries_held (entries_held)
	);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= sort_pkg::CNT_W'(sort_pkg::DEPTH))
		else $error("entry count exceeds table depth");

	a_resp_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |-> !(out_valid && !out_ready))
		else $error("result overwritten while still pending");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !sts.busy)
		else $error("word accepted while datapath busy");

	a_place_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |-> (!sts.busy && (sts.outcome != sort_pkg::ST_FULL) &&
			(sts.outcome != sort_pkg::ST_NOT_FOUND)))
		else $error("bank commit without a rewrite");
`endif

endmodule
